// ===== hdl/sspp_pkg.sv =====
package sspp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned POS_W     = 9;
	localparam int unsigned CFG_IDX_W = 1;

	// status, size and head come before the data bytes
	localparam logic [POS_W-1:0] HDR_BYTES = 9'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_BYTE = 1'b0,
		REG_END_BYTE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_STATUS = 3'd1,
		PH_SIZE   = 3'd2,
		PH_DATA   = 3'd3,
		PH_END    = 3'd4,
		PH_CHECK  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic              stored;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] byte_out;
		logic              frame_ok;
		logic [BYTE_W-1:0] frame_status;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic retry;
		logic head_hit;
		logic sum_ok;
	} dec_t;

endpackage

// ===== hdl/sspp_chan_if.sv =====
interface sspp_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/status_size_framed_packet_parser.sv =====
// Byte-framed packet parser. Takes one byte per cycle on byte_ch and returns one item per
// byte on result_ch: head, status, size, data bytes, end byte and checksum byte are reported
// with their frame position; the checksum byte of a good frame also raises frame_ok with the
// frame's status byte. A bad end or checksum byte is retried as a head byte in the same cycle.
// Frame state and result are registered on each accepted byte; the result sits in one output
// register, which refills in the cycle it is taken, so the sustained rate is one byte per
// cycle while result_ch.ready stays high. The user must write head_byte (index 0) and end_byte
// (index 1) through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module status_size_framed_packet_parser
	import sspp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	sspp_chan_if.sink            byte_ch,
	sspp_chan_if.source          result_ch
);

	logic [BYTE_W-1:0] head_q, end_q;
	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [BYTE_W-1:0] sum_q, sum_d, sum_add, chk_exp;
	logic [BYTE_W-1:0] size_q, size_d;
	logic [BYTE_W-1:0] stat_q, stat_d;
	logic [BYTE_W-1:0] b;
	dec_t              dec;
	out_item_t         res_d, res_q;
	logic              res_valid_q;
	logic              fire;

	assign b        = byte_ch.data.rx_byte;
	assign byte_ch.ready = !res_valid_q || result_ch.ready;
	assign fire     = byte_ch.valid && byte_ch.ready;
	assign cnt_inc  = cnt_q + 9'd1;
	assign sum_add  = sum_q + b;
	assign chk_exp  = 8'd0 - sum_q;

	assign result_ch.valid = res_valid_q;
	assign result_ch.data  = res_q;

	// phase decode
	always_comb begin
		dec          = '0;
		dec.head_hit = (b == head_q);
		dec.sum_ok   = (b == chk_exp);
		case (phase_q)
			PH_STATUS, PH_SIZE, PH_DATA: dec.take = 1'b1;
			PH_END: begin
				dec.take  = (b == end_q);
				dec.retry = (b != end_q);
			end
			PH_CHECK: begin
				dec.take  = dec.sum_ok;
				dec.retry = !dec.sum_ok;
			end
			default: dec.retry = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		size_d  = size_q;
		stat_d  = stat_q;
		if (dec.take) begin
			cnt_d = cnt_inc;
			sum_d = sum_add;
		end
		case (phase_q)
			PH_STATUS: begin
				stat_d  = b;
				phase_d = PH_SIZE;
			end
			PH_SIZE: begin
				size_d  = b;
				phase_d = (b == 8'd0) ? PH_END : PH_DATA;
			end
			PH_DATA: begin
				if (cnt_inc == ({1'b0, size_q} + HDR_BYTES))
					phase_d = PH_END;
			end
			PH_END: begin
				if (dec.take)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				if (dec.take)
					phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
		if (dec.retry) begin
			phase_d = PH_HUNT;
			if (dec.head_hit) begin
				cnt_d   = 9'd1;
				sum_d   = b;
				phase_d = PH_STATUS;
			end
		end
	end

	// result item
	always_comb begin
		res_d = '0;
		if (dec.take) begin
			res_d.stored   = 1'b1;
			res_d.position = cnt_q;
			res_d.byte_out = b;
		end
		if (dec.retry && dec.head_hit) begin
			res_d.stored   = 1'b1;
			res_d.position = '0;
			res_d.byte_out = b;
		end
		if (phase_q == PH_CHECK && dec.sum_ok) begin
			res_d.frame_ok     = 1'b1;
			res_d.frame_status = stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			end_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEAD_BYTE: head_q <= cfg_data;
				REG_END_BYTE:  end_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
			size_q  <= '0;
			stat_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			size_q  <= size_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (byte_ch.ready)
			res_valid_q <= byte_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

`ifndef SYNTHESIS
	a_ok_is_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.frame_ok |-> res_q.stored && res_q.position >= 9'd4)
		else $error("frame_ok on a byte that cannot close a frame");

	a_unstored_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.stored |-> res_q.position == '0 && res_q.byte_out == '0)
		else $error("unstored item carries position or byte");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> cnt_q < ({1'b0, size_q} + HDR_BYTES))
		else $error("data phase ran past the frame size");

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> byte_ch.ready)
		else $error("input stalled with empty result register");
`endif

endmodule

// ===== tb/sspp_frame_checker.sv =====
module sspp_frame_checker
	import sspp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	output int                   pending,
	output int                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [BYTE_W-1:0] head_cfg;
	logic [BYTE_W-1:0] end_cfg;

	phase_t            ph;
	logic [POS_W-1:0]  frame_cnt;
	logic [BYTE_W-1:0] frame_sum;
	logic [BYTE_W-1:0] frame_size;
	logic [BYTE_W-1:0] frame_stat;

	out_item_t expected_results[$];
	int        errs;

	function automatic out_item_t take_byte(input logic [BYTE_W-1:0] b);
		out_item_t r;
		r = '0;
		r.stored = 1'b1;
		r.position = frame_cnt;
		r.byte_out = b;
		frame_cnt = frame_cnt + 1'b1;
		frame_sum = frame_sum + b;
		return r;
	endfunction

	function automatic out_item_t retry_head(input logic [BYTE_W-1:0] b);
		out_item_t r;
		r = '0;
		ph = PH_HUNT;
		if (b == head_cfg) begin
			frame_cnt = '0;
			frame_sum = '0;
			r = take_byte(b);
			ph = PH_STATUS;
		end
		return r;
	endfunction

	function automatic out_item_t parse_byte(input logic [BYTE_W-1:0] b);
		out_item_t r;
		r = '0;
		case (ph)
			PH_STATUS: begin
				r = take_byte(b);
				frame_stat = b;
				ph = PH_SIZE;
			end
			PH_SIZE: begin
				r = take_byte(b);
				frame_size = b;
				ph = (b == '0) ? PH_END : PH_DATA;
			end
			PH_DATA: begin
				r = take_byte(b);
				if (frame_cnt == {1'b0, frame_size} + HDR_BYTES)
					ph = PH_END;
			end
			PH_END: begin
				if (b == end_cfg) begin
					r = take_byte(b);
					ph = PH_CHECK;
				end else begin
					r = retry_head(b);
				end
			end
			PH_CHECK: begin
				if (b == 8'(-frame_sum)) begin
					r = take_byte(b);
					r.frame_ok = 1'b1;
					r.frame_status = frame_stat;
					ph = PH_HUNT;
				end else begin
					r = retry_head(b);
				end
			end
			default: r = retry_head(b);
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			head_cfg   = '0;
			end_cfg    = '0;
			ph         = PH_HUNT;
			frame_cnt  = '0;
			frame_sum  = '0;
			frame_size = '0;
			frame_stat = '0;
			expected_results.delete();
			errs = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_HEAD_BYTE: head_cfg = cfg_data;
					REG_END_BYTE:  end_cfg  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_results.push_back(parse_byte(in_data.rx_byte));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("[%0t] unexpected result item: stored=%0d pos=%0d byte=%02h ok=%0d status=%02h",
							$realtime, out_data.stored, out_data.position, out_data.byte_out,
							out_data.frame_ok, out_data.frame_status);
				end else begin
					want = expected_results.pop_front();
					if (out_data.stored !== want.stored ||
					    out_data.position !== want.position ||
					    out_data.byte_out !== want.byte_out ||
					    out_data.frame_ok !== want.frame_ok ||
					    out_data.frame_status !== want.frame_status) begin
						errs++;
						if (errs <= 10) begin
							$display("[%0t] mismatch: expected stored=%0d pos=%0d byte=%02h ok=%0d status=%02h",
								$realtime, want.stored, want.position, want.byte_out,
								want.frame_ok, want.frame_status);
							$display("[%0t]           actual   stored=%0d pos=%0d byte=%02h ok=%0d status=%02h",
								$realtime, out_data.stored, out_data.position, out_data.byte_out,
								out_data.frame_ok, out_data.frame_status);
						end
					end
				end
			end
			pending <= expected_results.size();
			fail_count <= errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import sspp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BYTES = 80;

	typedef enum int {FLAW_NONE, FLAW_END, FLAW_SUM, FLAW_CUT} flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HEAD_BYTE;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	in_item_t             in_data = '0;
	logic                 out_ready = 1'b0;

	int pending;
	int fail_count;
	int cycle_cnt = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int queued = 0;

	logic [BYTE_W-1:0] tx_bytes[$];
	logic [BYTE_W-1:0] cur_head = '0;
	logic [BYTE_W-1:0] cur_end = '0;

	sspp_chan_if #(.item_t(in_item_t))  byte_ch();
	sspp_chan_if #(.item_t(out_item_t)) result_ch();

	assign byte_ch.valid   = in_valid;
	assign byte_ch.data    = in_data;
	assign result_ch.ready = out_ready;

	status_size_framed_packet_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	sspp_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (byte_ch.valid),
		.in_ready   (byte_ch.ready),
		.in_data    (byte_ch.data),
		.out_valid  (result_ch.valid),
		.out_ready  (result_ch.ready),
		.out_data   (result_ch.data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!in_valid || byte_ch.ready) begin
			if (tx_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_data.rx_byte <= tx_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic put_byte(input logic [BYTE_W-1:0] b);
		tx_bytes.push_back(b);
		queued++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (tx_bytes.size() != 0 || in_valid || pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wrong bytes sometimes equal the head byte so the retry starts a new frame
	function automatic logic [BYTE_W-1:0] wrong_byte(input logic [BYTE_W-1:0] good);
		logic [BYTE_W-1:0] b;
		if ($urandom_range(1) == 1 && cur_head != good)
			return cur_head;
		do
			b = BYTE_W'($urandom);
		while (b == good);
		return b;
	endfunction

	task automatic push_frame(input int size, input flaw_t flaw);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int cut;
		sum = cur_head;
		put_byte(cur_head);
		b = BYTE_W'($urandom);
		put_byte(b);
		sum += b;
		put_byte(BYTE_W'(size));
		sum += BYTE_W'(size);
		cut = (flaw == FLAW_CUT) ? $urandom_range(size) : size;
		for (int i = 0; i < cut; i++) begin
			b = ($urandom_range(7) == 0) ? cur_head : BYTE_W'($urandom);
			put_byte(b);
			sum += b;
		end
		if (flaw == FLAW_CUT)
			return;
		if (flaw == FLAW_END) begin
			put_byte(wrong_byte(cur_end));
			return;
		end
		put_byte(cur_end);
		sum += cur_end;
		if (flaw == FLAW_SUM)
			put_byte(wrong_byte(BYTE_W'(-sum)));
		else
			put_byte(BYTE_W'(-sum));
	endtask

	task automatic push_random_traffic(input int budget);
		int start;
		int pick;
		int size;
		start = queued;
		while (queued - start < budget) begin
			pick = $urandom_range(99);
			size = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
			if (pick < 60)
				push_frame(size, FLAW_NONE);
			else if (pick < 70)
				push_frame(size, FLAW_END);
			else if (pick < 80)
				push_frame(size, FLAW_SUM);
			else if (pick < 90)
				push_frame(size, FLAW_CUT);
			else
				repeat ($urandom_range(4, 1)) put_byte(BYTE_W'($urandom));
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] directed [25];
		logic [BYTE_W-1:0] heads [4];
		logic [BYTE_W-1:0] ends  [4];
		int idles  [4];
		int stalls [4];

		// reset config: head and end both 0
		directed = '{
			8'h00, 8'hFF, 8'h00, 8'h00, 8'h01,
			8'hFF,
			8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h7F,
			8'h00, 8'h01, 8'h00, 8'h55,
			8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
			8'h03, 8'h00, 8'h00, 8'hFD
		};
		idles  = '{0, 64, 0, 35};
		stalls = '{0, 0, 64, 35};

		heads[0] = 8'hFF;
		ends[0]  = 8'h00;
		heads[1] = BYTE_W'($urandom);
		ends[1]  = BYTE_W'($urandom);
		heads[2] = 8'h00;
		ends[2]  = 8'hFF;
		heads[3] = BYTE_W'($urandom);
		ends[3]  = heads[3];

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		foreach (directed[i])
			put_byte(directed[i]);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			cur_head = heads[p];
			cur_end = ends[p];
			write_reg(REG_HEAD_BYTE, cur_head);
			write_reg(REG_END_BYTE, cur_end);
			idle_pct = idles[p];
			stall_pct = stalls[p];
			@(negedge clk);
			push_random_traffic(PHASE_BYTES / 2);
			wait_drained();
			@(negedge clk);
			push_random_traffic(PHASE_BYTES / 2);
			if (p == 2)
				push_frame(255, FLAW_NONE);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
